// ===== hw/rtl/mte_pkg.sv =====
// shared types and constants of the multi-turn encoder tracker
// no dependencies; every other rtl file of the tracker but mte_div takes names from here
`default_nettype none

package mte_pkg;

	// fixed field widths
	localparam int SAMPLE_ANGLE_W = 14;
	localparam int JUMP_W         = 14;
	localparam int SCALE_W        = 24;
	localparam int INTERVAL_W     = 20;
	localparam int TIME_W         = 32;
	localparam int VEL_W          = 48;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;

	// low byte layout
	localparam int NO_MAGNET_BIT  = 1;

	// serial multiplier: operand b is taken one byte per cycle, msb first
	localparam int MUL_CHUNK      = 8;
	localparam int MUL_B_W        = 24;
	localparam int MUL_STEPS      = MUL_B_W / MUL_CHUNK;
	localparam int MUL_CNT_W      = 2;

	localparam logic [MUL_B_W-1:0] US_PER_S = 24'd1000000;

	// saturation bounds
	localparam logic [31:0]      POS_MAX   = 32'h7fff_ffff;
	localparam logic [31:0]      POS_MIN   = 32'h8000_0000;
	localparam logic [VEL_W-1:0] VEL_MAX   = 48'h7fff_ffff_ffff;
	localparam logic [VEL_W-1:0] VEL_MIN   = 48'h8000_0000_0000;
	localparam logic [15:0]      VOUT_MAX  = 16'h7fff;
	localparam logic [15:0]      VOUT_MIN  = 16'h8000;

	// register reset values
	localparam logic [SCALE_W-1:0]    SCALE_RST    = 24'd144000;
	localparam logic [JUMP_W-1:0]     JUMP_LOW_RST  = 14'd300;
	localparam logic [JUMP_W-1:0]     JUMP_HIGH_RST = 14'd16000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 20'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_Q16,
		CFG_JUMP_LOW,
		CFG_JUMP_HIGH,
		CFG_MIN_INTERVAL
	} mte_cfg_idx_t;

	typedef struct packed {
		logic [SCALE_W-1:0]    scale_q16;
		logic [JUMP_W-1:0]     jump_low;
		logic [JUMP_W-1:0]     jump_high;
		logic [INTERVAL_W-1:0] min_interval_us;
	} mte_cfg_t;

	typedef struct packed {
		logic [7:0]        high_byte;
		logic [7:0]        low_byte;
		logic [TIME_W-1:0] now_us;
		logic              rezero;
	} mte_in_t;

	// classified item passed from the front end to the back end
	typedef struct packed {
		logic                      frame_ok;
		logic [SAMPLE_ANGLE_W-1:0] sample_angle;
		logic [TIME_W-1:0]         now_us;
		logic                      rezero;
	} mte_item_t;

	typedef struct packed {
		logic signed [31:0] position_cdeg;
		logic signed [15:0] velocity_cdeg_s;
		logic [13:0]        angle_raw;
		logic signed [15:0] turn_total;
		logic               frame_ok;
		logic               jump_rejected;
	} mte_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mte_front.sv =====
// front end: takes encoder samples, checks flag and parity, registers the item
// uses mte_pkg
`default_nettype none

module mte_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sample_valid,
	output logic                sample_stall,
	input  mte_pkg::mte_in_t    sample,
	output logic                push_valid,
	input  wire                 push_stall,
	output mte_pkg::mte_item_t  push_item
);

	logic               valid_s1;
	mte_pkg::mte_item_t item_s1;
	mte_pkg::mte_item_t item_c;
	logic               load;
	logic [15:0]        frame_word;

	assign load         = !valid_s1 || !push_stall;
	assign sample_stall = !load;
	assign frame_word   = {sample.high_byte, sample.low_byte};

	// even parity over the whole frame word, no-magnet flag must be clear
	always_comb begin
		item_c.frame_ok     = !sample.low_byte[mte_pkg::NO_MAGNET_BIT] && !(^frame_word);
		item_c.sample_angle = {sample.high_byte, sample.low_byte[7:2]};
		item_c.now_us       = sample.now_us;
		item_c.rezero       = sample.rezero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && sample_valid) begin
			item_s1 <= item_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/mte_fifo.sv =====
// small item queue between front end and back end
// uses mte_pkg for the item type
`default_nettype none

module mte_fifo #(
	parameter int DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_valid,
	output logic                wr_stall,
	input  mte_pkg::mte_item_t  wr_item,
	output logic                rd_valid,
	input  wire                 rd_stall,
	output mte_pkg::mte_item_t  rd_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mte_pkg::mte_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_stall = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && !wr_stall;
	assign do_rd    = rd_valid && !rd_stall;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mte_div.sv =====
// restoring bit-serial divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module mte_div #(
	parameter int NUM_W = 58,
	parameter int DEN_W = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [NUM_W-1:0]  numer,
	input  wire [DEN_W-1:0]  denom,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             fit;
	logic             last_step;

	// numerator bits shift out of quo_q as quotient bits shift in
	assign rem_sh    = {rem_q, quo_q[NUM_W-1]};
	assign fit       = (rem_sh >= {1'b0, den_q});
	assign rem_sub   = rem_sh - {1'b0, den_q};
	assign last_step = busy_q && !start && (cnt_q == CNT_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= denom;
				quo_q  <= numer;
			end else if (busy_q) begin
				rem_q <= fit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fit};
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mte_back.sv =====
// back end: turn tracking, position scaling and filtered velocity sequencer
// uses mte_pkg and mte_div; shares one byte-serial multiply-accumulate
`default_nettype none

module mte_back #(
	parameter int ANGLE_BITS = 14
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mte_pkg::mte_cfg_t   cfg,
	input  wire                 item_valid,
	output logic                item_stall,
	input  mte_pkg::mte_item_t  item,
	output logic                result_valid,
	input  wire                 result_stall,
	output mte_pkg::mte_out_t   result
);

	localparam int D_W    = ANGLE_BITS + 1;
	localparam int T_W    = ANGLE_BITS + 16;
	localparam int A_W    = ANGLE_BITS + 24;
	localparam int P_W    = A_W + mte_pkg::MUL_B_W;
	localparam int PP_W   = A_W + mte_pkg::MUL_CHUNK;
	localparam int NUM_W  = ANGLE_BITS + 44;
	localparam int SH_W   = P_W - 16;
	localparam int VEL_W  = mte_pkg::VEL_W;
	localparam int V3_W   = VEL_W + 2;
	localparam int F_W    = VEL_W + 3;
	localparam int TIME_W = mte_pkg::TIME_W;
	localparam int CNT_W  = mte_pkg::MUL_CNT_W;
	localparam int MB_W   = mte_pkg::MUL_B_W;
	localparam int MC     = mte_pkg::MUL_CHUNK;
	localparam int JW     = mte_pkg::JUMP_W;
	localparam int CMP_W  = (ANGLE_BITS > JW) ? ANGLE_BITS : JW;
	localparam int IV_W   = mte_pkg::INTERVAL_W;
	localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);

	localparam logic signed [D_W-1:0] HALF_POS = D_W'(HALF_TURN);
	localparam logic signed [D_W-1:0] HALF_NEG = -HALF_POS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JUMP,
		ST_POS_LOAD,
		ST_POS_MUL,
		ST_POS_FIN,
		ST_VEL_CHK,
		ST_VEL_MUL1,
		ST_VEL_MID,
		ST_VEL_MUL2,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RAW,
		ST_FILT1,
		ST_FILT2,
		ST_FILT3,
		ST_OUT
	} state_t;

	state_t state_q;

	// current item
	logic                 ok_q;
	logic                 rezero_q;
	logic [TIME_W-1:0]    now_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic                 rejected_q;

	// tracker state
	logic [ANGLE_BITS-1:0] last_angle_q;
	logic [15:0]           turn_q;
	logic signed [31:0]    abs_pos_q;
	logic signed [31:0]    home_q;
	logic [ANGLE_BITS-1:0] vel_prev_q;
	logic [TIME_W-1:0]     last_vel_time_q;
	logic signed [VEL_W-1:0] velocity_q;

	// multiply-accumulate and velocity datapath
	logic [A_W-1:0]        mac_a_q;
	logic [MB_W-1:0]       mac_b_q;
	logic [CNT_W-1:0]      mac_cnt_q;
	logic [P_W-1:0]        acc_q;
	logic                  neg_q;
	logic [TIME_W-1:0]     dt_q;
	logic signed [VEL_W-1:0] raw_q;
	logic signed [V3_W-1:0]  vel3_q;
	logic signed [F_W-1:0]   sum_q;

	logic                  result_valid_q;
	mte_pkg::mte_out_t     result_q;

	// combinational helpers
	logic [ANGLE_BITS-1:0] angle_in;
	logic signed [D_W-1:0] delta;
	logic signed [D_W-1:0] delta_abs;
	logic                  jump_hit;
	logic signed [T_W-1:0] total;
	logic [T_W-1:0]        total_mag;
	logic [PP_W-1:0]       pp;
	logic                  mac_last;
	logic [SH_W-1:0]       sh;
	logic [31:0]           pos_val;
	logic [TIME_W-1:0]     dt;
	logic [IV_W-1:0]       need;
	logic                  vel_go;
	logic signed [D_W-1:0] vd;
	logic signed [D_W-1:0] vd_w;
	logic signed [D_W-1:0] vd_abs;
	logic                  div_start;
	logic                  div_done;
	logic [NUM_W-1:0]      div_quo;
	logic [VEL_W-1:0]      raw_val;
	logic signed [F_W-1:0] fadj;
	logic signed [32:0]    pos_diff;
	logic [31:0]           pos_sat;
	logic signed [VEL_W-1:0] vadj;
	logic [31:0]           vs;
	logic                  vs_fits;
	logic [15:0]           vout;

	assign angle_in = ANGLE_BITS'(item.sample_angle);

	// jump test
	assign delta     = signed'({1'b0, angle_q}) - signed'({1'b0, last_angle_q});
	assign delta_abs = delta[D_W-1] ? -delta : delta;
	assign jump_hit  = (CMP_W'(delta_abs[ANGLE_BITS-1:0]) > CMP_W'(cfg.jump_low)) &&
		(CMP_W'(delta_abs[ANGLE_BITS-1:0]) < CMP_W'(cfg.jump_high));

	// signed total count is turns and angle side by side
	assign total     = signed'({turn_q, last_angle_q});
	assign total_mag = total[T_W-1] ? T_W'(-total) : T_W'(total);

	// byte-serial multiply, msb byte of b first
	assign pp       = PP_W'(mac_a_q) * PP_W'(mac_b_q[MB_W-1 -: MC]);
	assign mac_last = (mac_cnt_q == CNT_W'(mte_pkg::MUL_STEPS - 1));

	// magnitude >> 16, signed back and saturated
	assign sh = acc_q[P_W-1:16];
	always_comb begin
		if (neg_q) begin
			pos_val = (sh > SH_W'(mte_pkg::POS_MIN)) ? mte_pkg::POS_MIN : -sh[31:0];
		end else begin
			pos_val = (sh > SH_W'(mte_pkg::POS_MAX)) ? mte_pkg::POS_MAX : sh[31:0];
		end
	end

	// velocity interval check and wrapped angle change
	assign dt     = now_q - last_vel_time_q;
	assign need   = (cfg.min_interval_us == '0) ? IV_W'(1) : cfg.min_interval_us;
	assign vel_go = (dt >= TIME_W'(need));
	assign vd     = signed'({1'b0, last_angle_q}) - signed'({1'b0, vel_prev_q});
	// adding or removing a full turn only flips the sign bit at this width
	assign vd_w   = (vd > HALF_POS || vd < HALF_NEG) ? {~vd[D_W-1], vd[D_W-2:0]} : vd;
	assign vd_abs = vd_w[D_W-1] ? -vd_w : vd_w;

	assign div_start = (state_q == ST_DIV_GO);

	mte_div #(
		.NUM_W(NUM_W),
		.DEN_W(TIME_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.numer   (acc_q[NUM_W-1:0]),
		.denom   (dt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		if (neg_q) begin
			raw_val = (div_quo > NUM_W'(mte_pkg::VEL_MIN)) ? mte_pkg::VEL_MIN : -div_quo[VEL_W-1:0];
		end else begin
			raw_val = (div_quo > NUM_W'(mte_pkg::VEL_MAX)) ? mte_pkg::VEL_MAX : div_quo[VEL_W-1:0];
		end
	end

	// divide by four toward zero; result always fits the filter width
	assign fadj = sum_q + (sum_q[F_W-1] ? F_W'(3) : F_W'(0));

	// output conversion
	assign pos_diff = 33'(abs_pos_q) - 33'(home_q);
	assign pos_sat  = (pos_diff[32] != pos_diff[31]) ?
		(pos_diff[32] ? mte_pkg::POS_MIN : mte_pkg::POS_MAX) : pos_diff[31:0];
	assign vadj     = velocity_q + (velocity_q[VEL_W-1] ? VEL_W'(65535) : VEL_W'(0));
	assign vs       = vadj[VEL_W-1:16];
	assign vs_fits  = (&vs[31:15]) || !(|vs[31:15]);
	assign vout     = vs_fits ? vs[15:0] : (vs[31] ? mte_pkg::VOUT_MIN : mte_pkg::VOUT_MAX);

	assign item_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			ok_q            <= 1'b0;
			rezero_q        <= 1'b0;
			now_q           <= '0;
			angle_q         <= '0;
			rejected_q      <= 1'b0;
			last_angle_q    <= '0;
			turn_q          <= '0;
			abs_pos_q       <= '0;
			home_q          <= '0;
			vel_prev_q      <= '0;
			last_vel_time_q <= '0;
			velocity_q      <= '0;
			mac_a_q         <= '0;
			mac_b_q         <= '0;
			mac_cnt_q       <= '0;
			acc_q           <= '0;
			neg_q           <= 1'b0;
			dt_q            <= '0;
			raw_q           <= '0;
			vel3_q          <= '0;
			sum_q           <= '0;
			result_valid_q  <= 1'b0;
			result_q        <= '0;
		end else begin
			// the output state sets valid itself
			if (result_valid_q && !result_stall && state_q != ST_OUT) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						ok_q     <= item.frame_ok;
						rezero_q <= item.rezero;
						now_q    <= item.now_us;
						angle_q  <= item.frame_ok ? angle_in : last_angle_q;
						state_q  <= ST_JUMP;
					end
				end

				ST_JUMP: begin
					if (rezero_q) begin
						turn_q          <= '0;
						last_angle_q    <= angle_q;
						vel_prev_q      <= angle_q;
						last_vel_time_q <= now_q;
						rejected_q      <= 1'b0;
						state_q         <= ST_POS_LOAD;
					end else if (jump_hit) begin
						rejected_q <= 1'b1;
						state_q    <= ST_VEL_CHK;
					end else begin
						rejected_q <= 1'b0;
						if (delta > HALF_POS) begin
							turn_q <= turn_q - 16'd1;
						end else if (delta < HALF_NEG) begin
							turn_q <= turn_q + 16'd1;
						end
						last_angle_q <= angle_q;
						state_q      <= ST_POS_LOAD;
					end
				end

				ST_POS_LOAD: begin
					mac_a_q   <= A_W'(total_mag);
					mac_b_q   <= cfg.scale_q16;
					mac_cnt_q <= '0;
					acc_q     <= '0;
					neg_q     <= total[T_W-1];
					state_q   <= ST_POS_MUL;
				end

				ST_POS_MUL: begin
					acc_q     <= (acc_q << MC) + P_W'(pp);
					mac_b_q   <= mac_b_q << MC;
					mac_cnt_q <= mac_cnt_q + CNT_W'(1);
					if (mac_last) begin
						state_q <= ST_POS_FIN;
					end
				end

				ST_POS_FIN: begin
					abs_pos_q <= pos_val;
					if (rezero_q) begin
						home_q  <= pos_val;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_VEL_CHK;
					end
				end

				ST_VEL_CHK: begin
					if (vel_go) begin
						mac_a_q         <= A_W'(vd_abs[ANGLE_BITS-1:0]);
						mac_b_q         <= cfg.scale_q16;
						mac_cnt_q       <= '0;
						acc_q           <= '0;
						neg_q           <= vd_w[D_W-1];
						dt_q            <= dt;
						vel_prev_q      <= last_angle_q;
						last_vel_time_q <= now_q;
						state_q         <= ST_VEL_MUL1;
					end else begin
						state_q <= ST_OUT;
					end
				end

				ST_VEL_MUL1: begin
					acc_q     <= (acc_q << MC) + P_W'(pp);
					mac_b_q   <= mac_b_q << MC;
					mac_cnt_q <= mac_cnt_q + CNT_W'(1);
					if (mac_last) begin
						state_q <= ST_VEL_MID;
					end
				end

				ST_VEL_MID: begin
					mac_a_q   <= acc_q[A_W-1:0];
					mac_b_q   <= mte_pkg::US_PER_S;
					mac_cnt_q <= '0;
					acc_q     <= '0;
					state_q   <= ST_VEL_MUL2;
				end

				ST_VEL_MUL2: begin
					acc_q     <= (acc_q << MC) + P_W'(pp);
					mac_b_q   <= mac_b_q << MC;
					mac_cnt_q <= mac_cnt_q + CNT_W'(1);
					if (mac_last) begin
						state_q <= ST_DIV_GO;
					end
				end

				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end

				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_RAW;
					end
				end

				ST_RAW: begin
					raw_q   <= raw_val;
					state_q <= ST_FILT1;
				end

				ST_FILT1: begin
					vel3_q  <= V3_W'(velocity_q) + (V3_W'(velocity_q) <<< 1);
					state_q <= ST_FILT2;
				end

				ST_FILT2: begin
					sum_q   <= F_W'(raw_q) + F_W'(vel3_q);
					state_q <= ST_FILT3;
				end

				ST_FILT3: begin
					velocity_q <= fadj[F_W-2:2];
					state_q    <= ST_OUT;
				end

				ST_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.position_cdeg   <= pos_sat;
						result_q.velocity_cdeg_s <= vout;
						result_q.angle_raw       <= 14'(last_angle_q);
						result_q.turn_total      <= turn_q;
						result_q.frame_ok        <= ok_q;
						result_q.jump_rejected   <= rejected_q;
						result_valid_q           <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multiturn_encoder_tracker.sv =====
// top level of the multi-turn encoder tracker: config registers and wiring
// uses mte_pkg, mte_front, mte_fifo and mte_back
// Tracks a 14-bit absolute encoder over many turns. Each sample item carries
// the two angle register bytes, a microsecond timestamp and a rezero flag; one
// result item comes back per sample with position in centidegrees relative to
// home, a 1/4-new low-pass velocity in centidegrees per second, the last good
// angle, the turn count and two status flags. Bad frames (no-magnet flag set
// or odd parity) reuse the last angle; jumps strictly between jump_low and
// jump_high are dropped as glitches. The front end classifies and registers
// each sample and feeds a short queue, so samples keep flowing in while the
// back end works. The back end handles one item at a time and takes the next
// only once idle again; a velocity update uses the bit-serial divider,
// which turns the angle change into a rate, one quotient bit per cycle.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the
// user must write it while no item is in flight; the block does not enforce it.
`default_nettype none

module multiturn_encoder_tracker #(
	parameter int ANGLE_BITS  = 14,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// sample channel
	input  wire                                 sample_valid,
	output logic                                sample_stall,
	input  mte_pkg::mte_in_t                    sample,
	// result channel
	output logic                                result_valid,
	input  wire                                 result_stall,
	output mte_pkg::mte_out_t                   result,
	// configuration write port
	input  wire                                 cfg_wr_en,
	input  wire [mte_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [mte_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	mte_pkg::mte_cfg_t  cfg_q;

	// front end to queue
	logic               push_valid;
	logic               push_stall;
	mte_pkg::mte_item_t push_item;

	// queue to back end
	logic               pop_valid;
	logic               pop_stall;
	mte_pkg::mte_item_t pop_item;

	// register writes, each field keeps its low bits of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q16       <= mte_pkg::SCALE_RST;
			cfg_q.jump_low        <= mte_pkg::JUMP_LOW_RST;
			cfg_q.jump_high       <= mte_pkg::JUMP_HIGH_RST;
			cfg_q.min_interval_us <= mte_pkg::INTERVAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mte_pkg::CFG_SCALE_Q16: begin
					cfg_q.scale_q16 <= cfg_wdata[mte_pkg::SCALE_W-1:0];
				end
				mte_pkg::CFG_JUMP_LOW: begin
					cfg_q.jump_low <= cfg_wdata[mte_pkg::JUMP_W-1:0];
				end
				mte_pkg::CFG_JUMP_HIGH: begin
					cfg_q.jump_high <= cfg_wdata[mte_pkg::JUMP_W-1:0];
				end
				mte_pkg::CFG_MIN_INTERVAL: begin
					cfg_q.min_interval_us <= cfg_wdata[mte_pkg::INTERVAL_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// flag and parity check, one register stage
	mte_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.push_valid  (push_valid),
		.push_stall  (push_stall),
		.push_item   (push_item)
	);

	// decouples sample intake from the multi-cycle back end
	mte_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_stall(push_stall),
		.wr_item (push_item),
		.rd_valid(pop_valid),
		.rd_stall(pop_stall),
		.rd_item (pop_item)
	);

	// turn tracking, scaling and velocity filter, with its own result register
	mte_back #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (pop_valid),
		.item_stall  (pop_stall),
		.item        (pop_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire
